### rtl/core/cpp_pkg.sv
package cpp_pkg;

    localparam int CB = 32;          // coordinate width
    localparam int LW = 31;          // length, radius and margin width
    localparam int WW = 2 * CB;      // width of squares and sums of squares
    localparam int RB = CB;          // radial norm width
    localparam int DIV_STEPS = CB;   // quotient bits resolved one per stage

    localparam logic REG_HALF_LENGTH = 1'b0;
    localparam logic REG_CYL_RADIUS  = 1'b1;

    typedef struct packed {
        logic          nx;
        logic          ny;
        logic          nz;
        logic [CB-1:0] ax;
        logic [CB-1:0] ay;
        logic [CB-1:0] az;
        logic          snap_x;
        logic          do_scale;
        logic          on_axis;
        logic          is_in;
        logic          all_in;
    } t_side;

    // sign and magnitude to a saturated two's complement coordinate
    function automatic logic [CB-1:0] sat_pack(input logic neg, input logic [CB:0] mag);
        logic [CB:0] lim;
        logic [CB:0] m;
        begin
            lim = neg ? ({{CB{1'b0}}, 1'b1} << (CB - 1))
                      : (({{CB{1'b0}}, 1'b1} << (CB - 1)) - 1'b1);
            m   = (mag > lim) ? lim : mag;
            sat_pack = neg ? (~m[CB-1:0] + 1'b1) : m[CB-1:0];
        end
    endfunction

endpackage

### rtl/core/cylinder_point_projection.sv
// Projects a signed Q16.16 point onto the surface of a closed cylinder lying
// along X (half length and radius set through the write port), and flags
// whether the point is inside and whether a sphere of the given margin around
// it lies wholly inside. One point is taken per cycle while the output is not
// held back, and each point yields exactly one result, in order, after the
// unpacking, squaring and classifying stages, the bit-per-stage radial square
// root, the radius product and the bit-per-stage division, and the output
// register. The whole pipeline advances together and holds while a result
// waits on the output.
// Write the registers only while no point is in flight.
module cylinder_point_projection
    import cpp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration writes
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [LW-1:0]  i_cfg_data,
    // point input
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,   // pos_x, pos_y, pos_z, margin, zero pad
    // projected output
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [103:0]   m_axis_tdata    // proj_x, proj_y, proj_z, is_inside,
                                           // all_inside, zero pad
);

    logic [LW-1:0] r_half_length;
    logic [LW-1:0] r_cyl_radius;

    // hold the registers; an index carries no code beyond the two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length <= '0;
            r_cyl_radius  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HALF_LENGTH: r_half_length <= i_cfg_data;
                REG_CYL_RADIUS:  r_cyl_radius  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance every stage unless a finished result is held back
    logic en;
    logic r_out_valid;
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    logic          f_valid;
    logic [WW-1:0] f_rt;
    t_side         f_side;

    cpp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (s_axis_tvalid),
        .i_pos_x       (s_axis_tdata[31:0]),
        .i_pos_y       (s_axis_tdata[63:32]),
        .i_pos_z       (s_axis_tdata[95:64]),
        .i_margin      (s_axis_tdata[126:96]),
        .i_half_length (r_half_length),
        .i_cyl_radius  (r_cyl_radius),
        .o_valid       (f_valid),
        .o_rt          (f_rt),
        .o_side        (f_side)
    );

    logic          q_valid;
    logic [RB-1:0] q_root;
    t_side         q_side;

    cpp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_rad   (f_rt),
        .i_side  (f_side),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    logic          d_valid;
    logic [CB:0]   d_qy, d_qz;
    t_side         d_side;

    cpp_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (q_valid),
        .i_norm       (q_root),
        .i_side       (q_side),
        .i_cyl_radius (r_cyl_radius),
        .o_valid      (d_valid),
        .o_qy         (d_qy),
        .o_qz         (d_qz),
        .o_side       (d_side)
    );

    // pick the surface: snapped cap, scaled wall, axis repair or unchanged
    logic [CB-1:0] n_px, n_py, n_pz;

    always_comb begin
        n_px = d_side.snap_x ? sat_pack(d_side.nx, {2'b0, r_half_length})
                             : sat_pack(d_side.nx, {1'b0, d_side.ax});
        if (d_side.do_scale) begin
            n_py = sat_pack(d_side.ny, d_qy);
            n_pz = sat_pack(d_side.nz, d_qz);
        end else if (d_side.on_axis) begin
            n_py = sat_pack(1'b0, {2'b0, r_cyl_radius});
            n_pz = '0;
        end else begin
            n_py = sat_pack(d_side.ny, {1'b0, d_side.ay});
            n_pz = sat_pack(d_side.nz, {1'b0, d_side.az});
        end
    end

    logic [103:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {6'b0, d_side.all_in, d_side.is_in, n_pz, n_py, n_px};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### rtl/core/cpp_front.sv
module cpp_front
    import cpp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [CB-1:0] i_pos_x,
    input  logic [CB-1:0] i_pos_y,
    input  logic [CB-1:0] i_pos_z,
    input  logic [LW-1:0] i_margin,
    input  logic [LW-1:0] i_half_length,
    input  logic [LW-1:0] i_cyl_radius,
    output logic          o_valid,
    output logic [WW-1:0] o_rt,
    output t_side         o_side
);

    // stage A: magnitudes and differences
    logic          r_va;
    logic          r_nx, r_ny, r_nz;
    logic [CB-1:0] r_ax, r_ay, r_az;
    logic          r_out_x, r_d_lt, r_m_le, r_axm_lt;
    logic [LW-1:0] r_rmd, r_rm;

    logic [CB-1:0] n_ax, n_ay, n_az;
    logic [LW-1:0] n_d;

    always_comb begin
        n_ax = i_pos_x[CB-1] ? (~i_pos_x + 1'b1) : i_pos_x;
        n_ay = i_pos_y[CB-1] ? (~i_pos_y + 1'b1) : i_pos_y;
        n_az = i_pos_z[CB-1] ? (~i_pos_z + 1'b1) : i_pos_z;
        n_d  = i_half_length - n_ax[LW-1:0];
    end

    // stage B: squares
    logic          r_vb;
    logic          r_nx_b, r_ny_b, r_nz_b;
    logic [CB-1:0] r_ax_b, r_ay_b, r_az_b;
    logic          r_out_x_b, r_d_lt_b, r_m_le_b, r_axm_lt_b;
    logic [WW-1:0] r_sq_y, r_sq_z, r_r2, r_rmd2, r_rm2;

    // stage C: classification
    logic          r_vc;
    logic [WW-1:0] r_rt;
    t_side         r_side;

    logic [WW-1:0] n_rt;
    logic          n_gt, n_cap;

    always_comb begin
        n_rt  = r_sq_y + r_sq_z;
        n_gt  = n_rt > r_r2;
        n_cap = !n_gt && !r_out_x_b && r_d_lt_b && (n_rt < r_rmd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx     <= i_pos_x[CB-1];
            r_ny     <= i_pos_y[CB-1];
            r_nz     <= i_pos_z[CB-1];
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_az     <= n_az;
            r_out_x  <= n_ax > {1'b0, i_half_length};
            r_d_lt   <= n_d < i_cyl_radius;
            r_rmd    <= i_cyl_radius - n_d;
            r_m_le   <= i_margin <= i_cyl_radius;
            r_rm     <= i_cyl_radius - i_margin;
            r_axm_lt <= ({1'b0, n_ax} + {2'b0, i_margin}) < {2'b0, i_half_length};

            r_nx_b     <= r_nx;
            r_ny_b     <= r_ny;
            r_nz_b     <= r_nz;
            r_ax_b     <= r_ax;
            r_ay_b     <= r_ay;
            r_az_b     <= r_az;
            r_out_x_b  <= r_out_x;
            r_d_lt_b   <= r_d_lt;
            r_m_le_b   <= r_m_le;
            r_axm_lt_b <= r_axm_lt;
            r_sq_y     <= WW'(r_ay) * WW'(r_ay);
            r_sq_z     <= WW'(r_az) * WW'(r_az);
            r_r2       <= WW'(i_cyl_radius) * WW'(i_cyl_radius);
            r_rmd2     <= WW'(r_rmd) * WW'(r_rmd);
            r_rm2      <= WW'(r_rm) * WW'(r_rm);

            r_rt            <= n_rt;
            r_side.nx       <= r_nx_b;
            r_side.ny       <= r_ny_b;
            r_side.nz       <= r_nz_b;
            r_side.ax       <= r_ax_b;
            r_side.ay       <= r_ay_b;
            r_side.az       <= r_az_b;
            r_side.snap_x   <= r_out_x_b || n_cap;
            r_side.do_scale <= n_gt || (!r_out_x_b && !n_cap && (n_rt != '0));
            r_side.on_axis  <= !n_gt && !r_out_x_b && !n_cap && (n_rt == '0);
            r_side.is_in    <= !r_out_x_b && (r_ax_b[LW-1:0] != i_half_length) && !n_gt;
            r_side.all_in   <= r_m_le_b && r_axm_lt_b && (n_rt <= r_rm2);
        end
    end

    assign o_valid = r_vc;
    assign o_rt    = r_rt;
    assign o_side  = r_side;

endmodule

### rtl/core/cpp_sqrt.sv
module cpp_sqrt
    import cpp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [WW-1:0] i_rad,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [RB-1:0] o_root,
    output t_side         o_side
);

    // one root bit per stage, most significant first; rem holds v - root^2
    logic            r_v   [0:RB];
    logic [WW-1:0]   r_rem [0:RB];
    logic [RB-1:0]   r_res [0:RB];
    t_side           r_sd  [0:RB];

    logic [WW+1:0]   n_trial [1:RB];
    logic            n_take  [1:RB];

    always_comb begin
        for (int k = 1; k <= RB; k++) begin
            n_trial[k] = ({{(WW-RB+2){1'b0}}, r_res[k-1]} << (RB + 1 - k))
                       + ({{(WW+1){1'b0}}, 1'b1} << (2 * (RB - k)));
            n_take[k]  = {2'b0, r_rem[k-1]} >= n_trial[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= RB; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= RB; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_rad;
            r_res[0] <= '0;
            r_sd[0]  <= i_side;
            for (int k = 1; k <= RB; k++) begin
                r_sd[k] <= r_sd[k-1];
                if (n_take[k]) begin
                    r_rem[k] <= r_rem[k-1] - n_trial[k][WW-1:0];
                    r_res[k] <= r_res[k-1] | (RB'(1) << (RB - k));
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_res[k] <= r_res[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[RB];
    assign o_root  = r_res[RB];
    assign o_side  = r_sd[RB];

endmodule

### rtl/core/cpp_scale.sv
module cpp_scale
    import cpp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RB-1:0] i_norm,
    input  t_side         i_side,
    input  logic [LW-1:0] i_cyl_radius,
    output logic          o_valid,
    output logic [CB:0]   o_qy,
    output logic [CB:0]   o_qz,
    output t_side         o_side
);

    // stage 0: products, stage 1: rounding add and overflow check,
    // stages 2.. : one quotient bit per stage for both lanes
    logic          r_v0;
    logic [WW-1:0] r_py, r_pz;
    logic [RB-1:0] r_n0;
    t_side         r_sd0;

    logic [WW-1:0] n_numy, n_numz, n_lim;

    always_comb begin
        n_numy = r_py + WW'(r_n0 >> 1);
        n_numz = r_pz + WW'(r_n0 >> 1);
        n_lim  = {r_n0, {(WW-RB){1'b0}}};
    end

    logic            r_v   [1:DIV_STEPS+1];
    logic [WW-1:0]   r_ry  [1:DIV_STEPS+1];
    logic [WW-1:0]   r_rz  [1:DIV_STEPS+1];
    logic [CB-1:0]   r_qy  [1:DIV_STEPS+1];
    logic [CB-1:0]   r_qz  [1:DIV_STEPS+1];
    logic [RB-1:0]   r_n   [1:DIV_STEPS+1];
    logic            r_oy  [1:DIV_STEPS+1];
    logic            r_oz  [1:DIV_STEPS+1];
    t_side           r_sd  [1:DIV_STEPS+1];

    logic [WW-1:0]   n_dv [2:DIV_STEPS+1];

    always_comb begin
        for (int k = 2; k <= DIV_STEPS + 1; k++) begin
            n_dv[k] = {{(WW-RB){1'b0}}, r_n[k-1]} << (DIV_STEPS + 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int k = 1; k <= DIV_STEPS + 1; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v0   <= i_valid;
            r_v[1] <= r_v0;
            for (int k = 2; k <= DIV_STEPS + 1; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_py    <= WW'(i_side.ay) * WW'(i_cyl_radius);
            r_pz    <= WW'(i_side.az) * WW'(i_cyl_radius);
            r_n0    <= i_norm;
            r_sd0   <= i_side;
            r_ry[1] <= n_numy;
            r_rz[1] <= n_numz;
            r_qy[1] <= '0;
            r_qz[1] <= '0;
            r_oy[1] <= n_numy >= n_lim;
            r_oz[1] <= n_numz >= n_lim;
            r_n[1]  <= r_n0;
            r_sd[1] <= r_sd0;
            for (int k = 2; k <= DIV_STEPS + 1; k++) begin
                r_n[k]  <= r_n[k-1];
                r_oy[k] <= r_oy[k-1];
                r_oz[k] <= r_oz[k-1];
                r_sd[k] <= r_sd[k-1];
                if (r_ry[k-1] >= n_dv[k]) begin
                    r_ry[k] <= r_ry[k-1] - n_dv[k];
                    r_qy[k] <= r_qy[k-1] | (CB'(1) << (DIV_STEPS + 1 - k));
                end else begin
                    r_ry[k] <= r_ry[k-1];
                    r_qy[k] <= r_qy[k-1];
                end
                if (r_rz[k-1] >= n_dv[k]) begin
                    r_rz[k] <= r_rz[k-1] - n_dv[k];
                    r_qz[k] <= r_qz[k-1] | (CB'(1) << (DIV_STEPS + 1 - k));
                end else begin
                    r_rz[k] <= r_rz[k-1];
                    r_qz[k] <= r_qz[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS+1];
    assign o_qy    = r_oy[DIV_STEPS+1] ? {(CB+1){1'b1}} : {1'b0, r_qy[DIV_STEPS+1]};
    assign o_qz    = r_oz[DIV_STEPS+1] ? {(CB+1){1'b1}} : {1'b0, r_qz[DIV_STEPS+1]};
    assign o_side  = r_sd[DIV_STEPS+1];

endmodule
